// File: design/fsbd_pkg.sv
// fsbd_pkg: shared constants, types and register codes of the binary dither unit
// no dependencies; imported by every module of the block
package fsbd_pkg;

  // image geometry
  localparam int MAX_COLS  = 1024;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int WID_W     = COL_W + 1;

  // error arithmetic, errors held at 16x scale
  localparam int ERR_W     = 16;
  localparam int RES_W     = ERR_W - 4;
  localparam int WIDE_W    = ERR_W + 2;
  localparam int ERR_MAX   = (2 ** (ERR_W - 1)) - 1;
  localparam int ERR_MIN   = -(2 ** (ERR_W - 1));
  localparam int HALVE_LIM = 2048;
  localparam int THRESH    = 128;
  localparam int WHITE_LVL = 255;

  // pixel and configuration fields
  localparam int PIX_W      = 8;
  localparam int LW_W       = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd640;

  // luma weights in 0.16 fixed point
  localparam int LUMA_ACC_W = 24;
  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;
  localparam logic [LUMA_ACC_W-1:0] LUMA_RND = 24'd32768;

  // row store: two banks of one row each
  localparam int ST_ADDR_W = COL_W + 1;
  localparam int ST_DEPTH  = 2 * MAX_COLS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE = 1'b0,
    CFG_LINE_WIDTH = 1'b1
  } cfg_reg_e;

  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [RES_W-1:0]  res_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic                 en;
    logic [ST_ADDR_W-1:0] addr;
    err_t                 data;
  } store_wr_t;

  typedef struct packed {
    logic is_white;
    res_t res;
    err_t wr_data;
    err_t acc_lo;
    err_t acc_hi;
  } dif_out_t;

endpackage

// File: design/fsbd_luma.sv
// fsbd_luma: picks the gray byte or converts red, green, blue to 8-bit luma
// depends on fsbd_pkg
module fsbd_luma (
  input  logic                     color_mode_i,
  input  logic [fsbd_pkg::PIX_W-1:0] gray_i,
  input  logic [fsbd_pkg::PIX_W-1:0] red_i,
  input  logic [fsbd_pkg::PIX_W-1:0] green_i,
  input  logic [fsbd_pkg::PIX_W-1:0] blue_i,
  output logic [fsbd_pkg::PIX_W-1:0] luma_o
);
  import fsbd_pkg::*;

  logic [LUMA_ACC_W-1:0] acc;

  always_comb begin
    acc = LUMA_ACC_W'(red_i) * LUMA_ACC_W'(LUMA_R)
        + LUMA_ACC_W'(green_i) * LUMA_ACC_W'(LUMA_G)
        + LUMA_ACC_W'(blue_i) * LUMA_ACC_W'(LUMA_B)
        + LUMA_RND;
    luma_o = color_mode_i ? acc[LUMA_ACC_W-1 -: PIX_W] : gray_i;
  end

endmodule

// File: design/fsbd_diffuse.sv
// fsbd_diffuse: one pixel of error diffusion, threshold and residual spreading
// depends on fsbd_pkg
module fsbd_diffuse (
  input  logic [fsbd_pkg::PIX_W-1:0] luma_i,
  input  fsbd_pkg::err_t             n_err_i,
  input  fsbd_pkg::res_t             res_prev_i,
  input  logic                       first_col_i,
  input  fsbd_pkg::err_t             acc_lo_i,
  input  fsbd_pkg::err_t             acc_hi_i,
  output fsbd_pkg::dif_out_t         dif_o
);
  import fsbd_pkg::*;

  function automatic err_t sat_err(input wide_t v);
    err_t r;
    if (v > wide_t'(ERR_MAX)) begin
      r = err_t'(ERR_MAX);
    end else if (v < wide_t'(ERR_MIN)) begin
      r = err_t'(ERR_MIN);
    end else begin
      r = err_t'(v);
    end
    return r;
  endfunction

  err_t  raw;
  err_t  rnd;
  err_t  e;
  err_t  e_div;
  wide_t sum;
  wide_t res_w;
  wide_t res7_prev;

  always_comb begin
    // error carried from the left neighbor within this row
    res7_prev = wide_t'(wide_t'(res_prev_i) * wide_t'(7));
    raw = first_col_i ? n_err_i : sat_err(wide_t'(n_err_i) + res7_prev);

    // halve large errors, toward zero
    rnd    = '0;
    rnd[0] = raw[ERR_W-1];
    if (raw > err_t'(HALVE_LIM) || raw < -err_t'(HALVE_LIM)) begin
      e = (raw + rnd) >>> 1;
    end else begin
      e = raw;
    end
    e_div = e >>> 4;

    sum   = wide_t'(luma_i) + wide_t'(e_div);
    dif_o.is_white = (sum >= wide_t'(THRESH));
    res_w = dif_o.is_white ? (sum - wide_t'(WHITE_LVL)) : sum;
    dif_o.res = res_t'(res_w);

    // weights 3 below left (final), 5 below, 1 below right
    dif_o.wr_data = sat_err(wide_t'(acc_lo_i) + wide_t'(res_w * wide_t'(3)));
    dif_o.acc_lo  = sat_err((first_col_i ? wide_t'(0) : wide_t'(acc_hi_i))
                            + wide_t'(res_w * wide_t'(5)));
    dif_o.acc_hi  = sat_err(res_w);
  end

endmodule

// File: design/fsbd_row_store.sv
// fsbd_row_store: error store for two rows, one write and one registered read per cycle
// depends on fsbd_pkg
module fsbd_row_store (
  input  logic                           clk_i,
  input  fsbd_pkg::store_wr_t            wr_i,
  input  logic                           rd_en_i,
  input  logic [fsbd_pkg::ST_ADDR_W-1:0] rd_addr_i,
  output fsbd_pkg::err_t                 rd_data_o
);
  import fsbd_pkg::*;

  err_t mem_q [ST_DEPTH];
  err_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/floyd_steinberg_binary_dither_unit.sv
// floyd_steinberg_binary_dither_unit: top level of the binary error diffusion ditherer
// depends on fsbd_pkg, fsbd_luma, fsbd_diffuse, fsbd_row_store
//
// Raster-order pixels go in one per beat and come out as one white/black bit per beat
// through Floyd-Steinberg error diffusion (weights 7, 5, 1, 3, errors kept at 16x
// scale and saturated to 16 bits, threshold 128). The block takes one pixel every
// clock unless the result channel stalls; a result passes the stage 1 input register
// and then the result register. That rate is set by the pixel-to-pixel error loop,
// closed in stage 1, and by the row store, which gives one read and one write per
// cycle. There is no clearing pass after reset: the block is ready at once. Errors
// for the row below are kept in a 2048-entry store (two banks); only the part
// written by the previous row is ever read, anything beyond it reads as zero, so
// frame start and row start cost nothing. Configuration (color_mode, line_width)
// is written through the cfg port, which is always ready; write it only while no
// pixel is in flight. line_width 0 acts as 1, and values above 1024 act as 1024.
module floyd_steinberg_binary_dither_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fsbd_pkg::PIX_W-1:0]      gray_i,
  input  logic [fsbd_pkg::PIX_W-1:0]      red_i,
  input  logic [fsbd_pkg::PIX_W-1:0]      green_i,
  input  logic [fsbd_pkg::PIX_W-1:0]      blue_i,
  input  logic                            frame_start_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            is_white_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fsbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fsbd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fsbd_pkg::*;

  // configuration
  logic            color_mode_q;
  logic [LW_W-1:0] line_width_q;
  logic [WID_W-1:0] w_eff;

  // front end: column tracking at accept time
  logic [COL_W-1:0] col_q, col_d;
  logic             bank_q, bank_d;
  logic [COL_W-1:0] col_start, pix_col;
  logic             bank_start, pix_bank;
  logic [WID_W-1:0] col_inc;
  logic             in_acc;
  logic [PIX_W-1:0] luma;

  // stage 1 input register
  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_bank_q;
  logic             s1_fs_q;
  logic [PIX_W-1:0] s1_luma_q;
  logic             byp_hit_q;
  err_t             byp_data_q;
  logic             s1_adv;

  // row being processed: pending below-row sums and last residual
  logic             open_valid_q;
  logic [COL_W-1:0] open_last_q;
  err_t             acc_lo_q;
  err_t             acc_hi_q;
  res_t             res_q;

  // previous row: its last column and the two entries never written to the store
  logic             tail_valid_q;
  logic [COL_W-1:0] tail_last_q;
  err_t             tail_lo_q;
  err_t             tail_hi_q;

  // lookup of the below-row error for the pixel in stage 1
  logic             prev_valid;
  logic [COL_W-1:0] prev_last;
  err_t             prev_lo, prev_hi;
  err_t             mem_val, n_err;
  logic             first_col;

  // store ports and datapath
  store_wr_t            st_wr;
  logic [ST_ADDR_W-1:0] rd_addr;
  err_t                 rd_data;
  dif_out_t             dif;

  // result register
  logic out_valid_q;
  logic is_white_q;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
      line_width_q <= LINE_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COLOR_MODE: color_mode_q <= cfg_data_i[0];
        CFG_LINE_WIDTH: line_width_q <= cfg_data_i[LW_W-1:0];
        default:        color_mode_q <= color_mode_q;
      endcase
    end
  end

  // clamp width into 1..MAX_COLS
  always_comb begin
    if (line_width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (line_width_q > LW_W'(MAX_COLS)) begin
      w_eff = WID_W'(MAX_COLS);
    end else begin
      w_eff = WID_W'(line_width_q);
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: stage 1 moves on whenever the result register is free or drains
  // ---------------------------------------------------------------------------
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // front end: column and bank of the accepted pixel
  // ---------------------------------------------------------------------------
  always_comb begin
    col_start  = frame_start_i ? '0 : col_q;
    bank_start = frame_start_i ? 1'b0 : bank_q;
    // a width shrunk below the current column ends the row first
    if ({1'b0, col_start} >= w_eff) begin
      pix_col  = '0;
      pix_bank = ~bank_start;
    end else begin
      pix_col  = col_start;
      pix_bank = bank_start;
    end
    col_inc = {1'b0, pix_col} + WID_W'(1);
    if (col_inc >= w_eff) begin
      col_d  = '0;
      bank_d = ~pix_bank;
    end else begin
      col_d  = col_inc[COL_W-1:0];
      bank_d = pix_bank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      bank_q <= 1'b0;
    end else if (in_acc) begin
      col_q  <= col_d;
      bank_q <= bank_d;
    end
  end

  fsbd_luma u_luma (
    .color_mode_i (color_mode_q),
    .gray_i       (gray_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .luma_o       (luma)
  );

  // previous row lives in the other bank; read it as the pixel is accepted
  assign rd_addr = {~pix_bank, pix_col};

  // ---------------------------------------------------------------------------
  // stage 1 input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q   <= pix_col;
      s1_bank_q  <= pix_bank;
      s1_fs_q    <= frame_start_i;
      s1_luma_q  <= luma;
      // entry written by stage 1 at this same edge: forward it
      byp_hit_q  <= st_wr.en && (st_wr.addr == rd_addr);
      byp_data_q <= st_wr.data;
    end
  end

  fsbd_row_store u_row_store (
    .clk_i     (clk_i),
    .wr_i      (st_wr),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // stage 1: find the below-row error, diffuse, write the finished entry
  // ---------------------------------------------------------------------------
  assign first_col = (s1_col_q == '0);

  always_comb begin
    // at row start the row just closed is still in the open registers
    if (first_col) begin
      prev_valid = open_valid_q && !s1_fs_q;
      prev_last  = open_last_q;
      prev_lo    = acc_lo_q;
      prev_hi    = acc_hi_q;
    end else begin
      prev_valid = tail_valid_q;
      prev_last  = tail_last_q;
      prev_lo    = tail_lo_q;
      prev_hi    = tail_hi_q;
    end
    mem_val = byp_hit_q ? byp_data_q : rd_data;
    n_err   = '0;
    if (prev_valid) begin
      if (s1_col_q < prev_last) begin
        n_err = mem_val;
      end else if (s1_col_q == prev_last) begin
        n_err = prev_lo;
      end else if ({1'b0, s1_col_q} == ({1'b0, prev_last} + WID_W'(1))) begin
        n_err = prev_hi;
      end
    end
  end

  fsbd_diffuse u_diffuse (
    .luma_i      (s1_luma_q),
    .n_err_i     (n_err),
    .res_prev_i  (res_q),
    .first_col_i (first_col),
    .acc_lo_i    (acc_lo_q),
    .acc_hi_i    (acc_hi_q),
    .dif_o       (dif)
  );

  // the entry below-left is complete once this pixel adds its share
  always_comb begin
    st_wr.en   = s1_adv && !first_col;
    st_wr.addr = {s1_bank_q, s1_col_q - COL_W'(1)};
    st_wr.data = dif.wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_valid_q <= 1'b0;
      tail_valid_q <= 1'b0;
    end else if (s1_adv) begin
      open_valid_q <= 1'b1;
      if (first_col) begin
        tail_valid_q <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      open_last_q <= s1_col_q;
      acc_lo_q    <= dif.acc_lo;
      acc_hi_q    <= dif.acc_hi;
      res_q       <= dif.res;
      if (first_col) begin
        tail_last_q <= open_last_q;
        tail_lo_q   <= acc_lo_q;
        tail_hi_q   <= acc_hi_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      is_white_q <= dif.is_white;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_white_o  = is_white_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_s1_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted beat did not reach stage 1");

  a_col_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_col_q != '0)) |->
      (open_valid_q && ({1'b0, s1_col_q} == ({1'b0, open_last_q} + WID_W'(1)))))
    else $error("mid-row pixel does not follow the previous column");

  a_byp_row_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && byp_hit_q) |-> (s1_col_q == '0))
    else $error("store forwarding outside a row start");

endmodule
